FILE: hw/rtl/fpa_pkg.sv
package fpa_pkg;

	// Field widths, fixed by the interface
	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int SIZE_W            = 16;
	localparam int OWNER_W           = 16;
	localparam int SLOT_W            = 4;

	// Action codes
	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_ALLOC   = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	// Fit policies (the unused code behaves as first fit)
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOFIT    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         fit_method;
		logic [SIZE_W-1:0]  req_size;
		logic [OWNER_W-1:0] owner_id;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_NOP,
		S_SCAN,
		S_ALLOC_FIN,
		S_REL_FIN,
		S_COMPACT,
		S_REL_DONE
	} state_t;

	// Which update the datapath applies together with the result beat
	typedef enum logic [2:0] {
		CM_NONE,
		CM_ADD,
		CM_ALLOC,
		CM_REL,
		CM_MISS,
		CM_NOP
	} commit_t;

	typedef struct packed {
		logic    load;
		logic    scan;
		logic    start_compact;
		commit_t commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] act_in;
		logic [1:0] act;
		logic       scan_end;
		logic       found;
		logic       out_free;
	} dp_sts_t;

endpackage

FILE: hw/rtl/fpa_ctrl.sv
module fpa_ctrl import fpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d           = state_q;
		cmd.load          = 1'b0;
		cmd.scan          = 1'b0;
		cmd.start_compact = 1'b0;
		cmd.commit        = CM_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					case (sts.act_in)
						ACT_ADD:     state_d = S_ADD;
						ACT_ALLOC:   state_d = S_SCAN;
						ACT_RELEASE: state_d = S_SCAN;
						default:     state_d = S_NOP;
					endcase
				end
			end
			S_ADD: begin
				if (sts.out_free) begin
					cmd.commit = CM_ADD;
					state_d    = S_IDLE;
				end
			end
			S_NOP: begin
				if (sts.out_free) begin
					cmd.commit = CM_NOP;
					state_d    = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = (sts.act == ACT_ALLOC) ? S_ALLOC_FIN : S_REL_FIN;
				end
			end
			S_ALLOC_FIN: begin
				if (sts.out_free) begin
					cmd.commit = CM_ALLOC;
					state_d    = S_IDLE;
				end
			end
			S_REL_FIN: begin
				if (!sts.found) begin
					if (sts.out_free) begin
						cmd.commit = CM_MISS;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.start_compact = 1'b1;
					state_d           = S_COMPACT;
				end
			end
			S_COMPACT: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = S_REL_DONE;
				end
			end
			S_REL_DONE: begin
				if (sts.out_free) begin
					cmd.commit = CM_REL;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/fpa_dp.sv
module fpa_dp import fpa_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  ctrl_cmd_t cmd,
	output dp_sts_t   sts,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output rsp_t      rsp
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	// Tables
	logic [SIZE_W-1:0]  part_size_mem [TABLE_ENTRIES];
	logic [OWNER_W-1:0] rec_owner_mem [TABLE_ENTRIES];
	logic [IDX_W-1:0]   rec_slot_mem  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] busy_q;
	logic [CNT_W-1:0]   part_count_q, rec_count_q;

	// Request and scan state
	req_t               req_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               compact_q;
	logic               found_q;
	logic [IDX_W-1:0]   pick_q;
	logic [SIZE_W-1:0]  pick_size_q;
	logic [IDX_W-1:0]   rel_slot_q;

	// Read stage
	logic               rd_v_s1, cmp_s1;
	logic [IDX_W-1:0]   ptr_s1;
	logic [SIZE_W-1:0]  size_rd_s1;
	logic [OWNER_W-1:0] owner_rd_s1;
	logic [IDX_W-1:0]   rslot_rd_s1;

	// Result register
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [CNT_W-1:0]   limit;
	logic               scan_end, issue;
	logic [IDX_W-1:0]   rd_addr;
	logic               cand, take_alloc, take_rel, cmp_wr;
	logic               add_ok, alloc_ok, out_free;
	logic               rec_we;
	logic [IDX_W-1:0]   rec_waddr;
	logic [OWNER_W-1:0] rec_wowner;
	logic [IDX_W-1:0]   rec_wslot;
	rsp_t               rsp_d;

	// Scan bounds: partitions for allocate, records for release and compaction
	assign limit    = (req_q.action == ACT_ALLOC) ? part_count_q : rec_count_q;
	assign scan_end = (ptr_q >= limit);
	assign issue    = cmd.scan && !scan_end;
	assign rd_addr  = ptr_q[IDX_W-1:0];

	// Evaluate the entry read last cycle
	assign cand = rd_v_s1 && !cmp_s1 && (req_q.action == ACT_ALLOC)
		&& !busy_q[ptr_s1] && (size_rd_s1 >= req_q.req_size);
	assign take_alloc = cand && (!found_q
		|| ((req_q.fit_method == FIT_BEST) && (size_rd_s1 < pick_size_q))
		|| ((req_q.fit_method == FIT_WORST) && (size_rd_s1 > pick_size_q)));
	assign take_rel = rd_v_s1 && !cmp_s1 && (req_q.action == ACT_RELEASE)
		&& !found_q && (owner_rd_s1 == req_q.owner_id);
	assign cmp_wr = rd_v_s1 && cmp_s1;

	assign add_ok   = (part_count_q < CNT_FULL);
	assign alloc_ok = found_q && (rec_count_q < CNT_FULL);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Record write port: append on allocate, shift down during compaction
	always_comb begin
		rec_we     = 1'b0;
		rec_waddr  = rec_count_q[IDX_W-1:0];
		rec_wowner = req_q.owner_id;
		rec_wslot  = pick_q;
		if (cmd.commit == CM_ALLOC && alloc_ok) begin
			rec_we = 1'b1;
		end else if (cmp_wr) begin
			rec_we     = 1'b1;
			rec_waddr  = IDX_W'(ptr_s1 - 1'b1);
			rec_wowner = owner_rd_s1;
			rec_wslot  = rslot_rd_s1;
		end
	end

	// Result of the committed request
	always_comb begin
		rsp_d.status = ST_OK;
		rsp_d.slot   = '0;
		case (cmd.commit)
			CM_ADD: begin
				if (add_ok) begin
					rsp_d.slot = SLOT_W'(part_count_q[IDX_W-1:0]);
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			CM_ALLOC: begin
				if (alloc_ok) begin
					rsp_d.slot = SLOT_W'(pick_q);
				end else begin
					rsp_d.status = ST_NOFIT;
				end
			end
			CM_REL:  rsp_d.slot   = SLOT_W'(rel_slot_q);
			CM_MISS: rsp_d.status = ST_NOTFOUND;
			default: rsp_d.status = ST_OK;
		endcase
	end

	// Memories
	always_ff @(posedge clk) begin
		if (cmd.commit == CM_ADD && add_ok) begin
			part_size_mem[part_count_q[IDX_W-1:0]] <= req_q.req_size;
		end
		if (issue) begin
			size_rd_s1 <= part_size_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_owner_mem[rec_waddr] <= rec_wowner;
			rec_slot_mem[rec_waddr]  <= rec_wslot;
		end
		if (issue) begin
			owner_rd_s1 <= rec_owner_mem[rd_addr];
			rslot_rd_s1 <= rec_slot_mem[rd_addr];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		ptr_s1 <= rd_addr;
		if (take_alloc) begin
			pick_q      <= ptr_s1;
			pick_size_q <= size_rd_s1;
		end
		if (take_rel) begin
			pick_q     <= ptr_s1;
			rel_slot_q <= rslot_rd_s1;
		end
		if (cmd.commit != CM_NONE) begin
			rsp_q <= rsp_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			part_count_q <= '0;
			rec_count_q  <= '0;
			ptr_q        <= '0;
			compact_q    <= 1'b0;
			found_q      <= 1'b0;
			rd_v_s1      <= 1'b0;
			cmp_s1       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			cmp_s1  <= compact_q;
			if (cmd.load) begin
				ptr_q     <= '0;
				compact_q <= 1'b0;
				found_q   <= 1'b0;
			end else if (cmd.start_compact) begin
				ptr_q     <= CNT_W'(pick_q) + 1'b1;
				compact_q <= 1'b1;
			end else if (issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (take_alloc || take_rel) begin
				found_q <= 1'b1;
			end
			case (cmd.commit)
				CM_ADD: begin
					if (add_ok) begin
						busy_q[part_count_q[IDX_W-1:0]] <= 1'b0;
						part_count_q <= part_count_q + 1'b1;
					end
				end
				CM_ALLOC: begin
					if (alloc_ok) begin
						busy_q[pick_q] <= 1'b1;
						rec_count_q    <= rec_count_q + 1'b1;
					end
				end
				CM_REL: begin
					busy_q[rel_slot_q] <= 1'b0;
					rec_count_q        <= rec_count_q - 1'b1;
				end
				default: begin
				end
			endcase
			// Output beat register
			if (cmd.commit != CM_NONE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.act_in   = req.action;
	assign sts.act      = req_q.action;
	assign sts.scan_end = scan_end;
	assign sts.found    = found_q;
	assign sts.out_free = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/fixed_partition_allocator.sv
// Fixed partition allocator. Keeps a table of up to TABLE_ENTRIES partitions (size, busy)
// and an ordered list of owner records. Each request beat gives exactly one result beat.
// Add appends a partition (status full when the table is full); allocate picks a free
// partition of at least req_size by first, best or worst fit, lower index winning ties;
// release frees the earliest record of owner_id and closes the gap in the list. One
// request is in work at a time; the result register lets the next request in while a
// result still waits. Tables sit in single-read-port memories scanned one entry per cycle;
// add and the unused action do not scan, allocate scans the partitions, and release scans
// the records and, on a hit, scans again from the record after it to close the gap. A
// finished result waits in the result register while the result side stalls.
module fixed_partition_allocator import fpa_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	fpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fpa_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	// An accepted request keeps the input side closed the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input open right after accepting a request");

	// A result is only committed when the output register can take it
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit != CM_NONE |-> sts.out_free)
		else $error("result committed over a waiting beat");

	// A new output beat always comes from a commit
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.commit != CM_NONE))
		else $error("output beat without commit");

	// Scanning never happens while idle
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> req_stall)
		else $error("scan while idle");
`endif

endmodule
